// ----- sv/gcfr_pkg.sv -----
// Shared constants, types and the gain code decoder for the gain command frame receiver.
`timescale 1ns / 1ps

package gcfr_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int COUNT_W     = 7;

   localparam logic [COUNT_W-1:0] FRAME_LEN = COUNT_W'(FRAME_BYTES);

   localparam logic [7:0] HDR_FIRST  = 8'h53;
   localparam logic [7:0] HDR_SECOND = 8'h4D;

   localparam logic [7:0] PID_CODE_LO = 8'h41;
   localparam logic [7:0] PID_CODE_HI = 8'h49;
   localparam logic [7:0] ALT_CODE_LO = 8'h77;
   localparam logic [7:0] ALT_CODE_HI = 8'h79;
   localparam logic [3:0] ALT_INDEX_BASE = 4'd9;

   localparam logic [COUNT_W-1:0] POS_TYPE      = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_VALUE_LO  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_VALUE_HI  = COUNT_W'(6);

   typedef struct packed {
      logic        known;
      logic [3:0]  index;
   } gain_map_type;

   typedef struct packed {
      logic        checksum_good;
      logic        gain_known;
      logic [3:0]  gain_index;
      logic [31:0] gain_value_bits;
   } gcfr_result_type;

   function automatic gain_map_type map_gain(input logic [7:0] code);
      gain_map_type m;
      logic [7:0]   d;
      m = '0;
      d = '0;
      if (code >= PID_CODE_LO && code <= PID_CODE_HI) begin
         d       = code - PID_CODE_LO;
         m.known = 1'b1;
         m.index = d[3:0];
      end else if (code >= ALT_CODE_LO && code <= ALT_CODE_HI) begin
         d       = code - ALT_CODE_LO;
         m.known = 1'b1;
         m.index = d[3:0] + ALT_INDEX_BASE;
      end
      return m;
   endfunction

endpackage

// ----- sv/gcfr_frame_track.sv -----
// Frame sync, byte sum and field capture for one byte per step.
`timescale 1ns / 1ps

module gcfr_frame_track
   import gcfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output logic            produce,
   output gcfr_result_type result
);

   logic [7:0]         last_byte_ff, last_byte_in;
   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]         running_sum_ff, running_sum_in;
   logic [7:0]         type_byte_ff, type_byte_in;
   logic [31:0]        value_shift_ff, value_shift_in;

   logic               hdr_hit;
   logic [COUNT_W-1:0] count_inc;
   gain_map_type       gmap;

   always_comb begin
      hdr_hit        = (last_byte_ff == HDR_FIRST) && (rx_byte == HDR_SECOND);
      count_inc      = byte_count_ff + COUNT_W'(1);
      last_byte_in   = rx_byte;
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      type_byte_in   = type_byte_ff;
      value_shift_in = value_shift_ff;
      produce        = 1'b0;

      if (hdr_hit) begin
         // restart the frame at the 0x53
         in_frame_in    = 1'b1;
         byte_count_in  = POS_TYPE;
         running_sum_in = HDR_FIRST + HDR_SECOND;
         type_byte_in   = '0;
         value_shift_in = '0;
      end else if (in_frame_ff) begin
         running_sum_in = running_sum_ff + rx_byte;
         if (byte_count_ff == POS_TYPE) begin
            type_byte_in = rx_byte;
         end else if (byte_count_ff >= POS_VALUE_LO && byte_count_ff <= POS_VALUE_HI) begin
            value_shift_in = {rx_byte, value_shift_ff[31:8]};
         end
         byte_count_in = count_inc;
         if (count_inc >= FRAME_LEN) begin
            produce       = 1'b1;
            in_frame_in   = 1'b0;
            byte_count_in = '0;
         end
      end

      gmap                   = map_gain(type_byte_in);
      result.checksum_good   = (running_sum_in == 8'h00);
      result.gain_known      = gmap.known;
      result.gain_index      = gmap.index;
      result.gain_value_bits = value_shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_byte_ff   <= '0;
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
         type_byte_ff   <= '0;
         value_shift_ff <= '0;
      end else if (step) begin
         last_byte_ff   <= last_byte_in;
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         type_byte_ff   <= type_byte_in;
         value_shift_ff <= value_shift_in;
      end
   end

endmodule

// ----- sv/gcfr_rsp_reg.sv -----
// Result register that holds one frame result until the consumer takes it.
`timescale 1ns / 1ps

module gcfr_rsp_reg
   import gcfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  gcfr_result_type load_data,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic            free,
   output gcfr_result_type rsp_data
);

   logic            valid_ff, valid_in;
   gcfr_result_type data_ff;

   always_comb begin
      free     = !valid_ff || !rsp_stall;
      valid_in = load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- sv/gain_command_frame_receiver_unit.sv -----
// Top level of the gain command frame receiver: input register, frame tracker, result register.
`timescale 1ns / 1ps
// A byte beat is registered in the input register, and a completing byte's result
// in the result register, which drives rsp_. Throughput: one byte beat per cycle
// unless req_stall holds a completing byte; the frame tracker updates its state once
// per byte. A frame gives at most one result beat. Reset (synchronous, active high)
// clears the sync state, the byte sum, the captured fields and both valid flags.

module gain_command_frame_receiver_unit
   import gcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_checksum_good,
   output logic        rsp_gain_known,
   output logic [3:0]  rsp_gain_index,
   output logic [31:0] rsp_gain_value_bits
);

   // Input register: one byte beat waiting for the tracker.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic            advance;
   logic            produce;
   logic            out_free;
   gcfr_result_type trk_result;
   gcfr_result_type out_result;

   // A byte that completes no frame always moves on; a completing byte waits
   // only while the result register is still held by the consumer.
   assign advance   = in_valid_ff && (!produce || out_free);
   // Stall the input only when the held byte cannot move this cycle.
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = (in_valid_ff && !advance) || (req_valid && !req_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the payload on every accepted beat; hold it otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   gcfr_frame_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .produce (produce),
      .result  (trk_result)
   );

   gcfr_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && produce),
      .load_data (trk_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .rsp_data  (out_result)
   );

   // Unpack the result beat onto its field ports.
   assign rsp_checksum_good   = out_result.checksum_good;
   assign rsp_gain_known      = out_result.gain_known;
   assign rsp_gain_index      = out_result.gain_index;
   assign rsp_gain_value_bits = out_result.gain_value_bits;

endmodule
